FILE: rtl/cps_pkg.sv
// Shared constants and helper functions for the convex polygon collision block.
// Used by the top level and the testbench package. No dependencies.
package cps_pkg;

  localparam int MAX_SIDES = 8;
  localparam int NUM_SLOTS = 4;
  localparam int ENTRIES   = NUM_SLOTS * MAX_SIDES;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int IDX_W     = $clog2(MAX_SIDES);
  localparam int CNT_W     = $clog2(MAX_SIDES + 1);

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_XFORM  = 2'd1;
  localparam logic [1:0] REQ_TEST   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [23:0] PI_Q16      = 24'sd205887;
  localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
  localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;

  function automatic logic signed [23:0] atan_q16(input logic [3:0] i);
    logic signed [23:0] t;
    case (i)
      4'd0:    t = 24'sd51472;
      4'd1:    t = 24'sd30386;
      4'd2:    t = 24'sd16055;
      4'd3:    t = 24'sd8150;
      4'd4:    t = 24'sd4091;
      4'd5:    t = 24'sd2047;
      4'd6:    t = 24'sd1024;
      4'd7:    t = 24'sd512;
      4'd8:    t = 24'sd256;
      4'd9:    t = 24'sd128;
      4'd10:   t = 24'sd64;
      4'd11:   t = 24'sd32;
      4'd12:   t = 24'sd16;
      4'd13:   t = 24'sd8;
      4'd14:   t = 24'sd4;
      default: t = 24'sd2;
    endcase
    return t;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(int'(slot) * MAX_SIDES + int'(idx));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -43'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/cps_req_if.sv
// Request channel of the convex polygon collision block: valid, ready and one request item.
// No dependencies.
interface cps_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         shape_slot;
  logic [1:0]         other_slot;
  logic [2:0]         corner_index;
  logic               last_corner;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [15:0] angle;
  logic [15:0]        scale;

  modport source (output valid, req_type, shape_slot, other_slot, corner_index, last_corner,
                  x_value, y_value, angle, scale, input ready);
  modport sink (input valid, req_type, shape_slot, other_slot, corner_index, last_corner,
                x_value, y_value, angle, scale, output ready);
endinterface

FILE: rtl/cps_res_if.sv
// Result channel of the convex polygon collision block: valid, ready and one result item.
// No dependencies.
interface cps_res_if;
  logic valid;
  logic ready;
  logic is_test_answer;
  logic collide;

  modport source (output valid, is_test_answer, collide, input ready);
  modport sink (input valid, is_test_answer, collide, output ready);
endinterface

FILE: rtl/cps_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/convex_polygon_sat_collision.sv
// Top level of the convex polygon collision block (separating axis test, fixed point).
// Depends on cps_pkg, cps_req_if, cps_res_if and cps_ram.
//
//   channel  direction  carries
//   req      in         req_type, slots, corner index, last mark, x/y, angle, scale
//   res      out        is_test_answer, collide
//
// A transform runs 16 CORDIC steps, then ten steps of the shared multiplier per corner.
// A test projects both shapes on the normal of up to every edge, every projection going
// through the one multiplier.
// Reset clears the corner counts and marks all world vertices as zero.
// A new request is taken only when the previous one is finished; a finished result waits
// in the output register while the next request is accepted.
module convex_polygon_sat_collision
  import cps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cps_req_if.sink  req,
  cps_res_if.source res
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CROT = 10'b0000000010,
    S_CFIN = 10'b0000000100,
    S_TMAC = 10'b0000001000,
    S_TE0  = 10'b0000010000,
    S_TE1  = 10'b0000100000,
    S_TE2  = 10'b0001000000,
    S_PMAC = 10'b0010000000,
    S_SEP  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;
  logic [3:0] step;

  logic [1:0]         r_slot, r_other;
  logic signed [31:0] xpos, ypos;
  logic [15:0]        r_scale;

  logic signed [23:0] z;
  logic signed [32:0] cx_c, cy_c;
  logic [3:0]         cit;
  logic               neg;
  logic signed [18:0] cosv, sinv;

  logic [IDX_W-1:0] ti;
  logic [CNT_W-1:0] tn;

  logic signed [65:0] acc, prod;
  logic signed [33:0] rx, ry;
  logic signed [31:0] wx, wy;

  logic [CNT_W-1:0]   na, nb;
  logic               side, pside;
  logic [IDX_W-1:0]   ei, vi;
  logic signed [31:0] v0x, v0y;
  logic signed [32:0] nx, ny;
  logic signed [65:0] amin, amax, bmin, bmax;

  logic res_test, res_col;
  logic ov, o_test, o_col;

  logic [CNT_W-1:0] corner_count [NUM_SLOTS];
  logic             wv_valid [ENTRIES];
  logic             rd_ok;

  logic              m_we;
  logic [ADDR_W-1:0] m_waddr, m_raddr, w_waddr, w_raddr;
  logic [63:0]       m_rdata, w_rdata;
  logic              w_we;

  cps_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_model_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata({req.x_value, req.y_value}),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  cps_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_world_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata({wx, wy}),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  logic accept;
  logic slot_ok, idx_ok;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic signed [23:0] za;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_ok   = int'(req.shape_slot) < NUM_SLOTS;
  assign idx_ok    = int'(req.corner_index) < MAX_SIDES;
  assign cnt_a     = slot_ok ? corner_count[req.shape_slot] : '0;
  assign cnt_b     = (int'(req.other_slot) < NUM_SLOTS) ? corner_count[req.other_slot] : '0;
  assign za        = {{5{req.angle[15]}}, req.angle, 3'b000};

  assign m_we    = accept && (req.req_type == REQ_LOAD) && slot_ok && idx_ok;
  assign m_waddr = entry_addr(req.shape_slot, IDX_W'(req.corner_index));
  assign m_raddr = entry_addr(r_slot, ti);

  logic [1:0]       e_slot, p_slot;
  logic [CNT_W-1:0] n_edge, n_p;
  logic [IDX_W-1:0] e1;

  assign e_slot = side ? r_other : r_slot;
  assign p_slot = pside ? r_other : r_slot;
  assign n_edge = side ? nb : na;
  assign n_p    = pside ? nb : na;
  assign e1     = ((CNT_W'(ei) + CNT_W'(1)) < n_edge) ? IDX_W'(CNT_W'(ei) + CNT_W'(1)) : '0;

  always_comb begin
    case (state)
      S_TE0:   w_raddr = entry_addr(e_slot, ei);
      S_TE1:   w_raddr = entry_addr(e_slot, e1);
      default: w_raddr = entry_addr(p_slot, vi);
    endcase
  end

  assign w_we    = (state == S_TMAC) && (step == 4'd9);
  assign w_waddr = entry_addr(r_slot, ti);

  logic signed [31:0] cx, cy, vx, vy;
  assign cx = m_rdata[63:32];
  assign cy = m_rdata[31:0];
  assign vx = rd_ok ? w_rdata[63:32] : '0;
  assign vy = rd_ok ? w_rdata[31:0] : '0;

  logic signed [33:0] ma, mb;
  logic signed [67:0] mul_full;

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_TMAC) begin
      case (step)
        4'd1: begin ma = 34'(cx); mb = 34'(cosv); end
        4'd2: begin ma = 34'(cy); mb = 34'(sinv); end
        4'd3: begin ma = 34'(cx); mb = 34'(sinv); end
        4'd4: begin ma = 34'(cy); mb = 34'(cosv); end
        4'd5: begin ma = rx; mb = $signed({18'b0, r_scale}); end
        4'd7: begin ma = ry; mb = $signed({18'b0, r_scale}); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state == S_PMAC) begin
      case (step)
        4'd1: begin ma = 34'(vx); mb = 34'(nx); end
        4'd2: begin ma = 34'(vy); mb = 34'(ny); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  assign mul_full = ma * mb;

  logic signed [32:0] xs, ys, xr, yr;
  logic signed [65:0] rsum, psum;
  logic signed [41:0] r8;
  logic signed [31:0] pos_sel;
  logic signed [42:0] tsum;
  logic               v_first;

  assign xs      = cx_c >>> cit;
  assign ys      = cy_c >>> cit;
  assign xr      = cx_c + 33'sd8192;
  assign yr      = cy_c + 33'sd8192;
  assign rsum    = acc + 66'sd32768;
  assign psum    = prod + 66'sd128;
  assign r8      = psum[49:8];
  assign pos_sel = (step == 4'd8) ? ypos : xpos;
  assign tsum    = 43'(r8) + 43'(pos_sel);
  assign v_first = (vi == '0);

  always_ff @(posedge clk) begin
    prod  <= mul_full[65:0];
    rd_ok <= wv_valid[w_raddr];
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      ov    <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        corner_count[k] <= '0;
      end
      for (int k = 0; k < ENTRIES; k++) begin
        wv_valid[k] <= 1'b0;
      end
    end else begin
      if (state == S_DONE && (!ov || res.ready)) begin
        ov <= 1'b1;
      end else if (ov && res.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            r_slot   <= req.shape_slot;
            r_other  <= req.other_slot;
            xpos     <= req.x_value;
            ypos     <= req.y_value;
            r_scale  <= req.scale;
            res_test <= (req.req_type == REQ_TEST);
            res_col  <= (req.req_type == REQ_TEST) && (cnt_a == '0 || cnt_b == '0);
            case (req.req_type)
              REQ_LOAD: begin
                if (slot_ok && idx_ok && req.last_corner) begin
                  corner_count[req.shape_slot] <= CNT_W'(int'(req.corner_index) + 1);
                end
                state <= S_DONE;
              end
              REQ_XFORM: begin
                if (slot_ok) begin
                  tn   <= cnt_a;
                  cx_c <= CORDIC_K;
                  cy_c <= '0;
                  cit  <= '0;
                  if (za > HALF_PI_Q16) begin
                    z   <= za - PI_Q16;
                    neg <= 1'b1;
                  end else if (za < -HALF_PI_Q16) begin
                    z   <= za + PI_Q16;
                    neg <= 1'b1;
                  end else begin
                    z   <= za;
                    neg <= 1'b0;
                  end
                  state <= S_CROT;
                end else begin
                  state <= S_DONE;
                end
              end
              REQ_TEST: begin
                na   <= cnt_a;
                nb   <= cnt_b;
                side <= 1'b0;
                ei   <= '0;
                if (cnt_a == '0 || cnt_b == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_TE0;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CROT: begin
          if (!z[23]) begin
            cx_c <= cx_c - ys;
            cy_c <= cy_c + xs;
            z    <= z - atan_q16(cit);
          end else begin
            cx_c <= cx_c + ys;
            cy_c <= cy_c - xs;
            z    <= z + atan_q16(cit);
          end
          cit <= cit + 4'd1;
          if (cit == 4'd15) begin
            state <= S_CFIN;
          end
        end
        S_CFIN: begin
          cosv <= neg ? -xr[32:14] : xr[32:14];
          sinv <= neg ? -yr[32:14] : yr[32:14];
          ti   <= '0;
          step <= '0;
          state <= (tn == '0) ? S_DONE : S_TMAC;
        end
        S_TMAC: begin
          step <= (step == 4'd9) ? 4'd0 : step + 4'd1;
          case (step)
            4'd2: acc <= prod;
            4'd3: acc <= acc - prod;
            4'd4: begin
              rx  <= rsum[49:16];
              acc <= prod;
            end
            4'd5: acc <= acc + prod;
            4'd6: begin
              ry <= rsum[49:16];
              wx <= sat32(tsum);
            end
            4'd8: wy <= sat32(tsum);
            4'd9: begin
              wv_valid[w_waddr] <= 1'b1;
              if ((CNT_W'(ti) + CNT_W'(1)) < tn) begin
                ti <= ti + IDX_W'(1);
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        S_TE0: begin
          state <= S_TE1;
        end
        S_TE1: begin
          v0x   <= vx;
          v0y   <= vy;
          state <= S_TE2;
        end
        S_TE2: begin
          nx    <= 33'(vy) - 33'(v0y);
          ny    <= 33'(v0x) - 33'(vx);
          pside <= 1'b0;
          vi    <= '0;
          step  <= '0;
          state <= S_PMAC;
        end
        S_PMAC: begin
          step <= (step == 4'd4) ? 4'd0 : step + 4'd1;
          case (step)
            4'd2: acc <= prod;
            4'd3: acc <= acc + prod;
            4'd4: begin
              if (!pside) begin
                if (v_first || acc < amin) amin <= acc;
                if (v_first || acc > amax) amax <= acc;
              end else begin
                if (v_first || acc < bmin) bmin <= acc;
                if (v_first || acc > bmax) bmax <= acc;
              end
              if ((CNT_W'(vi) + CNT_W'(1)) < n_p) begin
                vi <= vi + IDX_W'(1);
              end else if (!pside) begin
                pside <= 1'b1;
                vi    <= '0;
              end else begin
                state <= S_SEP;
              end
            end
            default: begin
            end
          endcase
        end
        S_SEP: begin
          if (amax < bmin || bmax < amin) begin
            res_col <= 1'b0;
            state   <= S_DONE;
          end else if ((CNT_W'(ei) + CNT_W'(1)) < n_edge) begin
            ei    <= ei + IDX_W'(1);
            state <= S_TE0;
          end else if (!side) begin
            side  <= 1'b1;
            ei    <= '0;
            state <= S_TE0;
          end else begin
            res_col <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov || res.ready) begin
            o_test <= res_test;
            o_col  <= res_col;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid          = ov;
  assign res.is_test_answer = o_test;
  assign res.collide        = o_col;

`ifndef SYNTH
  a_col_only_test: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.is_test_answer |-> !res.collide)
    else $error("collide set on a result that is not a test answer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while the previous one is still in work");

  a_vertex_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PMAC && step == 4'd1 |-> (CNT_W'(vi) < n_p))
    else $error("projection vertex index beyond the corner count");
`endif

endmodule

FILE: tb/cps_tb_if.sv
// Testbench-side interfaces: none needed beyond the RTL interfaces.
// This file holds the collision predictor package used by the testbench; depends on cps_pkg.
package cps_tb_pkg;
  import cps_pkg::*;

  typedef struct {
    logic [1:0]         req_type;
    logic [1:0]         shape_slot;
    logic [1:0]         other_slot;
    logic [2:0]         corner_index;
    logic               last_corner;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [15:0] angle;
    logic [15:0]        scale;
  } request_t;

  typedef struct {
    logic is_test_answer;
    logic collide;
  } answer_t;

  class collision_scoreboard;
    longint model_x[ENTRIES];
    longint model_y[ENTRIES];
    longint world_x[ENTRIES];
    longint world_y[ENTRIES];
    int     corners[NUM_SLOTS];
    answer_t pending_answers[$];
    int     mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        model_x[i] = 0;
        model_y[i] = 0;
        world_x[i] = 0;
        world_y[i] = 0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) corners[s] = 0;
      mismatches = 0;
    endfunction

    static function longint floor_shr(longint v, int n);
      return v >>> n;
    endfunction

    static function longint round_shr(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function void sin_cos(longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
      bit neg;
      z = ang * 8;
      x = 652032874;
      y = 0;
      neg = 0;
      if (z > 102944) begin
        z -= 205887;
        neg = 1;
      end else if (z < -102944) begin
        z += 205887;
        neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= tab[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += tab[i];
        end
        x = nx;
      end
      c = round_shr(x, 14);
      s = round_shr(y, 14);
      if (neg) begin
        c = -c;
        s = -s;
      end
    endfunction

    // Projections of Q16.16 vertices on 33-bit normals fit in 66 bits.
    function void extent(int slot, int n, longint nx, longint ny,
                         output logic signed [79:0] lo, output logic signed [79:0] hi);
      logic signed [79:0] p;
      for (int i = 0; i < n; i++) begin
        p = 80'(world_x[slot*MAX_SIDES+i]) * 80'(nx) + 80'(world_y[slot*MAX_SIDES+i]) * 80'(ny);
        if (i == 0 || p < lo) lo = p;
        if (i == 0 || p > hi) hi = p;
      end
    endfunction

    function logic overlap(int a, int b);
      int na, nb, sl, n, e0, e1;
      longint ex, ey;
      logic signed [79:0] amin, amax, bmin, bmax;
      na = corners[a];
      nb = corners[b];
      if (na == 0 || nb == 0) return 1'b1;
      for (int k = 0; k < 2; k++) begin
        sl = k ? b : a;
        n = k ? nb : na;
        for (int i = 0; i < n; i++) begin
          e0 = sl * MAX_SIDES + i;
          e1 = sl * MAX_SIDES + ((i + 1 < n) ? i + 1 : 0);
          ex = world_x[e1] - world_x[e0];
          ey = world_y[e1] - world_y[e0];
          extent(a, na, ey, -ex, amin, amax);
          extent(b, nb, ey, -ex, bmin, bmax);
          if (amax < bmin || bmax < amin) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_request(request_t r);
      answer_t ans;
      longint c, s, cx, cy, rx, ry;
      int e;
      ans.is_test_answer = 0;
      ans.collide = 0;
      if (r.req_type == REQ_LOAD) begin
        e = r.shape_slot * MAX_SIDES + r.corner_index;
        model_x[e] = r.x_value;
        model_y[e] = r.y_value;
        if (r.last_corner) corners[r.shape_slot] = r.corner_index + 1;
      end else if (r.req_type == REQ_XFORM) begin
        sin_cos(longint'(r.angle), c, s);
        for (int i = 0; i < corners[r.shape_slot]; i++) begin
          e = r.shape_slot * MAX_SIDES + i;
          cx = model_x[e];
          cy = model_y[e];
          rx = round_shr(cx * c - cy * s, 16);
          ry = round_shr(cx * s + cy * c, 16);
          world_x[e] = clamp32(round_shr(rx * longint'(r.scale), 8) + longint'(r.x_value));
          world_y[e] = clamp32(round_shr(ry * longint'(r.scale), 8) + longint'(r.y_value));
        end
      end else if (r.req_type == REQ_TEST) begin
        ans.is_test_answer = 1;
        ans.collide = overlap(r.shape_slot, r.other_slot);
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic is_test, logic coll);
      answer_t exp_ans;
      if (pending_answers.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
        return;
      end
      exp_ans = pending_answers.pop_front();
      if (exp_ans.is_test_answer !== is_test) begin
        $error("is_test_answer: expected %0d actual %0d", exp_ans.is_test_answer, is_test);
        mismatches++;
      end
      if (exp_ans.collide !== coll) begin
        $error("collide: expected %0d actual %0d", exp_ans.collide, coll);
        mismatches++;
      end
    endfunction
  endclass
endpackage

FILE: tb/tb_convex_polygon_sat_collision.sv
// Testbench for convex_polygon_sat_collision: random loads, transforms and collision tests,
// checked against a predictor class. Depends on cps_pkg, cps_tb_pkg and the RTL interfaces.
module tb_convex_polygon_sat_collision;
  import cps_pkg::*;
  import cps_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  cps_req_if req();
  cps_res_if res();

  convex_polygon_sat_collision dut (.clk(clk), .rst(rst), .req(req), .res(res));

  collision_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  longint cycles;
  bit loaded[NUM_SLOTS][MAX_SIDES];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd20000000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) board.check_answer(res.is_test_answer, res.collide);
  end

  initial begin
    res.ready = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      res.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The request stays on the bus until the next falling edge, where the next call
  // either replaces it or drops valid.
  task automatic send(request_t r);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1;
    req.req_type <= r.req_type;
    req.shape_slot <= r.shape_slot;
    req.other_slot <= r.other_slot;
    req.corner_index <= r.corner_index;
    req.last_corner <= r.last_corner;
    req.x_value <= r.x_value;
    req.y_value <= r.y_value;
    req.angle <= r.angle;
    req.scale <= r.scale;
    do @(posedge clk); while (!req.ready);
    board.note_request(r);
  endtask

  task automatic idle_req();
    @(negedge clk);
    req.valid <= 0;
  endtask

  function automatic logic signed [31:0] coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic request_t blank();
    request_t r;
    r.req_type = REQ_LOAD;
    r.shape_slot = 0;
    r.other_slot = 0;
    r.corner_index = 0;
    r.last_corner = 0;
    r.x_value = 0;
    r.y_value = 0;
    r.angle = 0;
    r.scale = 16'h0100;
    return r;
  endfunction

  function automatic request_t rand_item();
    request_t r;
    r = blank();
    r.req_type = 2'($urandom_range(3));
    r.shape_slot = 2'($urandom_range(3));
    r.other_slot = 2'($urandom_range(3));
    r.corner_index = 3'($urandom_range(7));
    r.last_corner = 1'($urandom_range(1));
    r.x_value = coord();
    r.y_value = coord();
    r.angle = 16'($signed($urandom_range(0, 51472)) - 25736);
    r.scale = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 768));
    return r;
  endfunction

  // Loads a full shape of n corners so that every transform reads written corners.
  task automatic load_shape(int slot, int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_item();
      r.req_type = REQ_LOAD;
      r.shape_slot = 2'(slot);
      r.corner_index = 3'(i);
      r.last_corner = (i == n - 1);
      send(r);
      loaded[slot][i] = 1;
    end
  endtask

  task automatic random_item();
    request_t r;
    int ok;
    r = rand_item();
    if (r.req_type == REQ_LOAD) begin
      if (r.last_corner) begin
        ok = 1;
        for (int i = 0; i < r.corner_index; i++) ok &= loaded[r.shape_slot][i];
        if (!ok) r.last_corner = 0;
      end
      loaded[r.shape_slot][r.corner_index] = 1;
    end
    send(r);
  endtask

  task automatic run_phase(int n);
    int k;
    int n_c;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin
          n_c = $urandom_range(1, MAX_SIDES);
          load_shape($urandom_range(3), n_c);
          k += n_c;
        end
        default: begin
          random_item();
          k++;
        end
      endcase
    end
  endtask

  initial begin
    request_t r;
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    req.valid = 0;
    req.req_type = REQ_LOAD;
    req.shape_slot = 0;
    req.other_slot = 0;
    req.corner_index = 0;
    req.last_corner = 0;
    req.x_value = 0;
    req.y_value = 0;
    req.angle = 0;
    req.scale = 0;
    rst = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    r = blank();
    r.req_type = REQ_TEST;
    send(r);
    r.req_type = REQ_UNUSED;
    send(r);
    load_shape(0, 3);
    load_shape(1, MAX_SIDES);
    r = blank();
    r.req_type = REQ_TEST;
    r.other_slot = 1;
    send(r);
    r = blank();
    r.req_type = REQ_XFORM;
    r.angle = 16'sd25736;
    r.scale = 16'hffff;
    r.x_value = 32'sh7fffffff;
    send(r);
    r.shape_slot = 1;
    r.angle = -16'sd25736;
    r.x_value = 32'sh80000000;
    r.y_value = 32'sh80000000;
    r.scale = 0;
    send(r);
    r = blank();
    r.req_type = REQ_TEST;
    r.other_slot = 1;
    send(r);
    r.shape_slot = 1;
    r.other_slot = 1;
    send(r);
    r.shape_slot = 2;
    send(r);

    recv_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      repeat (6) random_item();
    join

    send_idle_pct = 32;
    recv_idle_pct = 51;
    run_phase(580);
    send_idle_pct = 51;
    recv_idle_pct = 32;
    run_phase(580);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(570);
    idle_req();

    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
